@@ src/kmp_pattern_matcher_macros.svh @@
// assertion macros shared by the kmp checker
`ifndef KMP_PATTERN_MATCHER_MACROS_SVH
`define KMP_PATTERN_MATCHER_MACROS_SVH

// property checked only outside reset
`define KMP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("kmp check failed");

// property that also covers the reset cycles
`define KMP_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("kmp reset check failed");

`endif

@@ src/kmp_pkg.sv @@
// shared constants and register codes of the kmp pattern matcher
`timescale 1ns / 1ps

package kmp_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int LEN_W       = IDX_W + 1;
  localparam int PAT_WORDS   = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int POS_W       = 32;
  localparam int CNT_W       = 32;
  localparam int BYTE_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 3'd4;

endpackage

@@ src/kmp_pattern_matcher.sv @@
// streaming knuth-morris-pratt matcher, top level
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------
//  in      | input     | in_valid / in_ready   | in_text_byte, in_end_of_text
//  out     | output    | out_valid / out_ready | out_match_start, out_match_number
//  cfg     | input     | cfg_we                | cfg_index, cfg_data
//
//  a text byte is taken in S_IDLE, then compared in S_STEP, with one S_FALL per
//  border fallback and one more when it completes a match; each S_FALL reads the ram
//  a match waits in the step state while the output register still holds a beat
//  after reset and after every pattern or length write the border table is rebuilt
//  through S_BINIT, S_BSTEP and S_BFALL, with in_ready low
//  reset is synchronous; it clears the pattern, counters and the output, sets length to 1
`timescale 1ns / 1ps

module kmp_pattern_matcher import kmp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // text input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_text_byte,
  input  logic                  in_end_of_text,
  // match output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [POS_W-1:0]      out_match_start,
  output logic [CNT_W-1:0]      out_match_number,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [5:0] {
    S_BINIT = 6'b000001,  // clear border entry zero
    S_BSTEP = 6'b000010,  // one step of the table build
    S_BFALL = 6'b000100,  // build fallback, ram read in flight
    S_IDLE  = 6'b001000,  // waiting for a text byte
    S_STEP  = 6'b010000,  // compare text byte against pattern
    S_FALL  = 6'b100000   // match fallback, ram read in flight
  } state_t;

  state_t state_r, state_nxt;

  // pattern registers, viewed as a byte array with byte 0 lowest
  logic [PAT_WORDS-1:0][CFG_DATA_W-1:0] pat_r, pat_nxt;
  logic [MAX_PATTERN-1:0][BYTE_W-1:0]   pat_bytes;
  logic [LEN_W-1:0]                     len_r, len_nxt;

  // matcher state kept between bytes
  logic [LEN_W-1:0] mlen_r, mlen_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // working registers of the current byte or table build
  logic [LEN_W-1:0]  m_r, m_nxt;
  logic [LEN_W-1:0]  i_r, i_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [BYTE_W-1:0] c_r, c_nxt;
  logic              eot_r, eot_nxt;
  logic              done_r, done_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [POS_W-1:0] out_start_r, out_start_nxt;
  logic [CNT_W-1:0] out_number_r, out_number_nxt;

  // border table ram
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [IDX_W-1:0] ram_rdata;

  // effective pattern length and helpers
  logic [LEN_W-1:0] n_eff;
  logic [IDX_W-1:0] n_m1;
  logic             bk_eq;
  logic             mc_eq;
  logic [LEN_W-1:0] m_inc;
  logic [IDX_W-1:0] k_inc;
  logic             finish;
  logic [LEN_W-1:0] fin_val;

  assign pat_bytes = pat_r;

  // zero length counts as one, anything above the maximum saturates
  always_comb begin
    if (len_r == '0) begin
      n_eff = LEN_W'(1);
    end else if (len_r > LEN_W'(MAX_PATTERN)) begin
      n_eff = LEN_W'(MAX_PATTERN);
    end else begin
      n_eff = len_r;
    end
  end

  assign n_m1  = IDX_W'(n_eff - LEN_W'(1));
  assign bk_eq = pat_bytes[i_r[IDX_W-1:0]] == pat_bytes[k_r];
  assign mc_eq = pat_bytes[m_r[IDX_W-1:0]] == c_r;
  assign m_inc = m_r + LEN_W'(mc_eq);
  assign k_inc = k_r + IDX_W'(bk_eq);

  // every ram read is issued in a cycle with no write, and the data is used
  // in the next cycle, so a read never overlaps a write to the same entry
  kmp_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_PATTERN)
  ) u_border_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    pat_nxt        = pat_r;
    len_nxt        = len_r;
    mlen_nxt       = mlen_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    m_nxt          = m_r;
    i_nxt          = i_r;
    k_nxt          = k_r;
    c_nxt          = c_r;
    eot_nxt        = eot_r;
    done_nxt       = done_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_start_nxt  = out_start_r;
    out_number_nxt = out_number_r;
    ram_we         = 1'b0;
    ram_waddr      = i_r[IDX_W-1:0];
    ram_wdata      = k_inc;
    ram_raddr      = '0;
    finish         = 1'b0;
    fin_val        = m_inc;

    case (state_r)
      S_BINIT: begin
        // border of the one-byte prefix is always zero
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '0;
        i_nxt     = LEN_W'(1);
        k_nxt     = '0;
        state_nxt = S_BSTEP;
      end
      S_BSTEP: begin
        if (i_r >= n_eff) begin
          state_nxt = S_IDLE;
        end else if (k_r != '0 && !bk_eq) begin
          ram_raddr = k_r - IDX_W'(1);
          state_nxt = S_BFALL;
        end else begin
          ram_we = 1'b1;
          k_nxt  = k_inc;
          i_nxt  = i_r + LEN_W'(1);
        end
      end
      S_BFALL: begin
        k_nxt     = ram_rdata;
        state_nxt = S_BSTEP;
      end
      S_IDLE: begin
        if (in_valid) begin
          c_nxt     = in_text_byte;
          eot_nxt   = in_end_of_text;
          m_nxt     = (mlen_r >= n_eff) ? '0 : mlen_r;
          done_nxt  = 1'b0;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (m_r != '0 && !mc_eq) begin
          ram_raddr = IDX_W'(m_r - LEN_W'(1));
          state_nxt = S_FALL;
        end else if (m_inc == n_eff) begin
          // full match: hold here until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_nxt  = 1'b1;
            out_start_nxt  = pos_r - POS_W'(n_m1);
            out_number_nxt = cnt_r;
            cnt_nxt        = cnt_r + CNT_W'(1);
            ram_raddr      = n_m1;
            done_nxt       = 1'b1;
            state_nxt      = S_FALL;
          end
        end else begin
          finish = 1'b1;
        end
      end
      S_FALL: begin
        m_nxt = {1'b0, ram_rdata};
        if (done_r) begin
          finish  = 1'b1;
          fin_val = {1'b0, ram_rdata};
        end else begin
          state_nxt = S_STEP;
        end
      end
      default: begin
        state_nxt = S_BINIT;
      end
    endcase

    // close out the byte; end of text clears position, count and match length
    if (finish) begin
      state_nxt = S_IDLE;
      if (eot_r) begin
        mlen_nxt = '0;
        pos_nxt  = '0;
        cnt_nxt  = '0;
      end else begin
        mlen_nxt = fin_val;
        pos_nxt  = pos_r + POS_W'(1);
      end
    end

    // pattern and length writes restart the table build and drop the partial match
    if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_0: pat_nxt[0] = cfg_data;
        REG_PATTERN_1: pat_nxt[1] = cfg_data;
        REG_PATTERN_2: pat_nxt[2] = cfg_data;
        REG_PATTERN_3: pat_nxt[3] = cfg_data;
        REG_LENGTH:    len_nxt    = cfg_data[LEN_W-1:0];
        default: ;
      endcase
      if (cfg_index <= REG_LENGTH) begin
        mlen_nxt  = '0;
        state_nxt = S_BINIT;
      end
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BINIT;
      pat_r       <= '0;
      len_r       <= LEN_W'(1);
      mlen_r      <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pat_r       <= pat_nxt;
      len_r       <= len_nxt;
      mlen_r      <= mlen_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    m_r          <= m_nxt;
    i_r          <= i_nxt;
    k_r          <= k_nxt;
    c_r          <= c_nxt;
    eot_r        <= eot_nxt;
    out_start_r  <= out_start_nxt;
    out_number_r <= out_number_nxt;
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_match_start  = out_start_r;
  assign out_match_number = out_number_r;

endmodule

@@ src/kmp_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/kmp_checker.sv @@
// port-level assertions for the kmp pattern matcher, bound to the top level
`timescale 1ns / 1ps
`include "kmp_pattern_matcher_macros.svh"

module kmp_checker import kmp_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [POS_W-1:0]      out_match_start,
  input logic [CNT_W-1:0]      out_match_number,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index
);

  // a held result beat stays valid
  `KMP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)

  // and keeps its payload
  `KMP_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable({out_match_start, out_match_number}))

  // reset starts a table build with nothing to deliver
  `KMP_ASSERT_RST(a_reset_build, !rst_n |=> !in_ready && !out_valid)

  // a register write rebuilds the table before more text is taken
  `KMP_ASSERT(a_cfg_rebuild, cfg_we && cfg_index <= REG_LENGTH |=> !in_ready)

  // an accepted text byte takes the block out of idle, so in_ready drops
  `KMP_ASSERT(a_one_byte, in_valid && in_ready |=> !in_ready)

endmodule

bind kmp_pattern_matcher kmp_checker u_kmp_checker (.*);

@@ tb/tb_kmp_pattern_matcher.sv @@
// testbench for the streaming kmp pattern matcher, checks every match beat against a predictor
`timescale 1ns / 1ps

module tb_kmp_pattern_matcher;
  import kmp_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 3 * MAX_PATTERN + 32;
  localparam int unsigned CYCLE_LIMIT   = 400_000;
  localparam int unsigned RANDOM_ITEMS  = 480;

  localparam logic [CFG_IDX_W-1:0] WORD_REG [PAT_WORDS] =
    '{REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3};

  typedef struct packed {
    logic [POS_W-1:0] start;
    logic [CNT_W-1:0] number;
  } match_t;

  logic                  clk;
  logic                  rst_n            = 1'b0;
  logic                  in_valid         = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_text_byte     = '0;
  logic                  in_end_of_text   = 1'b0;
  logic                  out_valid;
  logic                  out_ready        = 1'b0;
  logic [POS_W-1:0]      out_match_start;
  logic [CNT_W-1:0]      out_match_number;
  logic                  cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index        = '0;
  logic [CFG_DATA_W-1:0] cfg_data         = '0;

  kmp_pattern_matcher u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_match_start  (out_match_start),
    .out_match_number (out_match_number),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // matcher predictor: its own copy of the pattern, the border table and the
  // running text state
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] pat_word [PAT_WORDS];
  logic [LEN_W-1:0]      len_reg;
  logic [IDX_W-1:0]      border [MAX_PATTERN];
  logic [LEN_W-1:0]      cur_len;
  logic [POS_W-1:0]      position;
  logic [CNT_W-1:0]      found;

  match_t      pending_matches [$];
  int unsigned fail_count  = 0;
  int unsigned items_sent  = 0;
  int unsigned cycle_count = 0;

  // idling controls, changed per phase
  bit src_gaps    = 1'b0;
  bit sink_stalls = 1'b0;
  bit calm        = 1'b0;
  bit valid_up    = 1'b0;
  int stall_left  = 0;

  // length zero acts as one, anything past the maximum saturates
  function automatic int unsigned active_len();
    int unsigned n;
    n = len_reg;
    if (n == 0) n = 1;
    if (n > MAX_PATTERN) n = MAX_PATTERN;
    return n;
  endfunction

  function automatic logic [BYTE_W-1:0] pat_at(input int unsigned i);
    logic [IDX_W-1:0] j;
    j = i[IDX_W-1:0];
    return pat_word[j[4:3]][j[2:0]*BYTE_W +: BYTE_W];
  endfunction

  // longest proper border of every pattern prefix
  function automatic void rebuild_borders();
    int unsigned n;
    int unsigned k;
    n = active_len();
    k = 0;
    border[0] = '0;
    for (int unsigned i = 1; i < n; i++) begin
      while (k > 0 && pat_at(i) != pat_at(k)) k = border[k-1];
      if (pat_at(i) == pat_at(k)) k++;
      border[i] = k[IDX_W-1:0];
    end
  endfunction

  function automatic void clear_matcher();
    for (int i = 0; i < PAT_WORDS; i++) pat_word[i] = '0;
    for (int i = 0; i < MAX_PATTERN; i++) border[i] = '0;
    len_reg  = LEN_W'(1);
    rebuild_borders();
    cur_len  = '0;
    position = '0;
    found    = '0;
  endfunction

  // a pattern or length write rebuilds the table and drops the partial match only
  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_PATTERN_0: pat_word[0] = data;
      REG_PATTERN_1: pat_word[1] = data;
      REG_PATTERN_2: pat_word[2] = data;
      REG_PATTERN_3: pat_word[3] = data;
      REG_LENGTH:    len_reg     = data[LEN_W-1:0];
      default:       return;
    endcase
    rebuild_borders();
    cur_len = '0;
  endfunction

  // advance the text state by one byte, queue the match it completes if any
  function automatic void predict_byte(input logic [BYTE_W-1:0] b, input logic eot);
    int unsigned n;
    int unsigned m;
    match_t      hit;
    n = active_len();
    m = cur_len;
    if (m >= n) m = 0;
    while (m > 0 && pat_at(m) != b) m = border[m-1];
    if (pat_at(m) == b) m++;
    if (m == n) begin
      hit.start  = position - POS_W'(n - 1);
      hit.number = found;
      pending_matches.push_back(hit);
      found = found + 1'b1;
      m = border[n-1];
    end
    cur_len  = m[LEN_W-1:0];
    position = position + 1'b1;
    // end of text: the byte counts, then everything starts over
    if (eot) begin
      cur_len  = '0;
      position = '0;
      found    = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall bursts, every accepted beat checked in order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (sink_stalls && !calm && $urandom_range(0, 4) == 0) begin
      // start a stall burst
      stall_left <= $urandom_range(0, 5);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic note_fault(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    match_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_matches.size() == 0) begin
        note_fault($sformatf("match beat with nothing expected, start %0d number %0d",
                             out_match_start, out_match_number));
      end else begin
        want = pending_matches.pop_front();
        if (out_match_start !== want.start)
          note_fault($sformatf("match_start expected %0d actual %0d",
                               want.start, out_match_start));
        if (out_match_number !== want.number)
          note_fault($sformatf("match_number expected %0d actual %0d",
                               want.number, out_match_number));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // text side
  // ---------------------------------------------------------------------------
  task automatic lower_input();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up  = 1'b0;
    end
  endtask

  // one text beat; valid stays up after the handshake so back-to-back beats
  // never lower and raise it in the same step
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eot);
    if (src_gaps && !calm && $urandom_range(0, 3) == 0) begin
      lower_input();
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_end_of_text <= eot;
    valid_up        = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b, eot);
    items_sent++;
  endtask

  // hold the text until every expected match is back, then let the block settle
  task automatic wait_drain();
    lower_input();
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // registers are only written with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_register(idx, data);
    cfg_we    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // reset pattern is a single zero byte, so every zero byte matches
  task automatic test_reset_pattern();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // "ABA" in "ABABA": the second match overlaps the first
  task automatic test_overlapping_matches();
    write_reg(REG_PATTERN_0, 64'hFFFF_FFFF_FF41_4241);
    // upper bits set, only the low six count
    write_reg(REG_LENGTH, 64'hFFFF_FFFF_FFFF_FFC3);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h41, 1'b1);
  endtask

  // length zero acts as one; an oversized length saturates and the short
  // text then never matches
  task automatic test_length_limits();
    write_reg(REG_LENGTH, 64'h0);
    send_byte(8'h41, 1'b0);
    for (int w = 0; w < PAT_WORDS; w++) write_reg(WORD_REG[w], 64'h5A5A_5A5A_5A5A_5A5A);
    write_reg(REG_LENGTH, 64'h3F);
    repeat (3) send_byte(8'h5A, 1'b0);
    send_byte(8'h5A, 1'b1);
  endtask

  // a write in the middle of a text drops the partial match, position and count go on
  task automatic test_config_mid_text();
    write_reg(REG_PATTERN_0, 64'h0000_0000_0000_4241);
    write_reg(REG_LENGTH, 64'h2);
    send_byte(8'h41, 1'b0);
    write_reg(REG_LENGTH, 64'h2);
    send_byte(8'h42, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h41, 1'b0);
  endtask

  // end of text cuts a partial match; a match on the last byte still counts
  task automatic test_end_of_text_mid_match();
    send_byte(8'h41, 1'b1);
    send_byte(8'h42, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // random texts: fresh pattern over a small alphabet, then texts made mostly
  // of whole and broken pattern copies
  // ---------------------------------------------------------------------------
  task automatic run_random_phase(input int unsigned text_items, input bit last_phase);
    logic [BYTE_W-1:0]     alphabet [4];
    logic [BYTE_W-1:0]     text_q [$];
    logic [CFG_DATA_W-1:0] word;
    logic [CFG_DATA_W-1:0] len_word;
    int unsigned           alpha_n;
    int unsigned           len_code;
    int unsigned           picked;
    int unsigned           n;
    int unsigned           chunk;
    bit                    len_first;

    alpha_n = $urandom_range(1, 4);
    for (int i = 0; i < 4; i++) alphabet[i] = BYTE_W'($urandom_range(0, 255));

    picked = $urandom_range(0, 99);
    if (picked < 62)      len_code = $urandom_range(1, 6);
    else if (picked < 78) len_code = $urandom_range(7, MAX_PATTERN - 1);
    else if (picked < 88) len_code = MAX_PATTERN;
    else if (picked < 94) len_code = 0;
    else                  len_code = $urandom_range(MAX_PATTERN + 1, 63);
    len_word       = {$urandom(), $urandom()};
    len_word[LEN_W-1:0] = len_code[LEN_W-1:0];

    len_first = $urandom_range(0, 1);
    if (len_first) write_reg(REG_LENGTH, len_word);
    for (int w = 0; w < PAT_WORDS; w++) begin
      for (int b = 0; b < 8; b++) begin
        if ($urandom_range(0, 9) == 0)
          word[b*BYTE_W +: BYTE_W] = BYTE_W'($urandom_range(0, 255));
        else word[b*BYTE_W +: BYTE_W] = alphabet[$urandom_range(0, alpha_n - 1)];
      end
      write_reg(WORD_REG[w], word);
    end
    if (!len_first) write_reg(REG_LENGTH, len_word);

    src_gaps    = $urandom_range(0, 3) != 0;
    sink_stalls = $urandom_range(0, 3) != 0;
    calm        = last_phase;

    n = active_len();
    if (text_items < 3 * n) text_items = 3 * n;
    while (text_q.size() < text_items) begin
      picked = $urandom_range(0, 99);
      if (picked < 45) begin
        for (int unsigned i = 0; i < n; i++) text_q.push_back(pat_at(i));
      end else if (picked < 65) begin
        chunk = $urandom_range(1, n);
        for (int unsigned i = 0; i < chunk; i++) text_q.push_back(pat_at(i));
      end else if (picked < 92) begin
        text_q.push_back(alphabet[$urandom_range(0, alpha_n - 1)]);
      end else begin
        text_q.push_back(BYTE_W'($urandom_range(0, 255)));
      end
    end

    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], ($urandom_range(0, 29) == 0) ||
                           (i == text_q.size() - 1 && $urandom_range(0, 1) == 1));
      // now and then hold the text until all matches are back
      if (!calm && $urandom_range(0, 79) == 0) wait_drain();
    end
  endtask

  task automatic test_random_texts();
    int unsigned first_item;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS - 40)
      run_random_phase($urandom_range(30, 60), 1'b0);
    // closing stretch without any idling
    run_random_phase(40, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    clear_matcher();

    test_reset_pattern();
    test_overlapping_matches();
    test_length_limits();
    test_config_mid_text();
    test_end_of_text_mid_match();
    test_random_texts();

    // every expected beat back, then a quiet tail for stray beats
    wait_drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
